// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

	localparam int OCC_W = 5;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POP    = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] item_data;
		logic signed [31:0] item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_data;
		logic signed [31:0] out_priority;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

	// Broadcast operation for every cell of the row.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/spq_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
interface spq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted row: holds an entry, shifts or takes the new one.
module spq_cell import spq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic                  occ,
	input  logic signed [31:0]    new_prio,
	input  logic [DATA_WIDTH-1:0] new_data,
	input  logic                  prev_keep,
	input  logic signed [31:0]    prev_prio,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic signed [31:0]    next_prio,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic signed [31:0]    prio,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  keep
);

	logic signed [31:0]    prio_q;
	logic [DATA_WIDTH-1:0] data_q;

	// Entry stays put when it ranks at or above the newcomer.
	assign keep = occ && (prio_q >= new_prio);
	assign prio = prio_q;
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!keep) begin
				if (prev_keep) begin
					prio_q <= new_prio;
					data_q <= new_data;
				end else begin
					prio_q <= prev_prio;
					data_q <= prev_data;
				end
			end
		end else if (ctl.pop) begin
			prio_q <= next_prio;
			data_q <= next_data;
		end
	end

endmodule

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a row of DEPTH entry cells.
//
//  channel  dir  payload                                          handshake
//  req      in   req_type, item_data, item_priority               valid/ready
//  rsp      out  status, out_data, out_priority, occupancy        valid/ready
//
// Each transaction on req gives one rsp transaction, held in the output register.
// One request per cycle while req.ready is high: the whole row compares against
// the new priority and shifts in the same cycle an insert or pop is taken.
// req.ready drops only while a result sits in the output register unclaimed.
// Reset clears the entry count and the output valid; cell contents need none.
module sorted_priority_queue_unit import spq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	spq_stream_if.sink   req,
	spq_stream_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  accept;
	logic                  full;
	logic                  empty;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] new_data;
	logic [DATA_WIDTH+31:0] din_ext;
	logic [DATA_WIDTH+31:0] dout_ext;
	logic [CNT_W+OCC_W-1:0] occ_ext;
	logic                  rsp_vld_q;
	rsp_t                  rsp_q;
	rsp_t                  rsp_nxt;

	logic signed [31:0]    prio_a [DEPTH];
	logic [DATA_WIDTH-1:0] data_a [DEPTH];
	logic                  keep_a [DEPTH];

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	assign ctl.ins = accept && (req.payload.req_type == REQ_INSERT) && !full;
	assign ctl.pop = accept && (req.payload.req_type == REQ_POP) && !empty;

	assign din_ext  = {{DATA_WIDTH{1'b0}}, req.payload.item_data};
	assign new_data = din_ext[DATA_WIDTH-1:0];
	assign dout_ext = {32'b0, data_a[0]};

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

	always_comb begin
		rsp_nxt              = '0;
		rsp_nxt.occupancy    = occ_ext[OCC_W-1:0];
		if (req.payload.req_type == REQ_INSERT) begin
			rsp_nxt.status = full ? ST_OVER : ST_DONE;
		end else if (empty) begin
			rsp_nxt.status = ST_UNDER;
		end else begin
			rsp_nxt.status       = ST_DONE;
			rsp_nxt.out_data     = dout_ext[31:0];
			rsp_nxt.out_priority = prio_a[0];
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                  prev_keep;
			logic signed [31:0]    prev_prio;
			logic [DATA_WIDTH-1:0] prev_data;
			logic signed [31:0]    next_prio;
			logic [DATA_WIDTH-1:0] next_data;

			if (i == 0) begin : g_head
				assign prev_keep = 1'b1;
				assign prev_prio = req.payload.item_priority;
				assign prev_data = new_data;
			end else begin : g_body
				assign prev_keep = keep_a[i-1];
				assign prev_prio = prio_a[i-1];
				assign prev_data = data_a[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign next_prio = prio_a[i];
				assign next_data = data_a[i];
			end else begin : g_mid
				assign next_prio = prio_a[i+1];
				assign next_data = data_a[i+1];
			end

			spq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occ      (CNT_W'(i) < count_q),
				.new_prio (req.payload.item_priority),
				.new_data (new_data),
				.prev_keep(prev_keep),
				.prev_prio(prev_prio),
				.prev_data(prev_data),
				.next_prio(next_prio),
				.next_data(next_data),
				.prio     (prio_a[i]),
				.data     (data_a[i]),
				.keep     (keep_a[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH % (1 << OCC_W));

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("rsp transaction changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.status == ST_DONE || rsp_payload.status == ST_UNDER
			|| rsp_payload.status == ST_OVER))
		else $error("illegal status code");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == ST_UNDER |->
			rsp_payload.occupancy == '0 && rsp_payload.out_data == '0
			&& rsp_payload.out_priority == '0)
		else $error("underflow with nonempty queue or nonzero data");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == ST_OVER |->
			rsp_payload.occupancy == FULL_OCC && rsp_payload.out_data == '0)
		else $error("overflow reported on a queue that is not full");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result register is blocked");

endmodule

bind sorted_priority_queue_unit spq_checker #(
	.DEPTH(DEPTH)
) u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_payload(rsp.payload)
);

// ===== bench/sorted_priority_queue_unit_test.sv =====
// Testbench for the sorted priority queue: random insert/pop traffic against a local model.
module sorted_priority_queue_unit_test import spq_pkg::*;;

	localparam int QDEPTH    = 16;
	localparam int N_ITEMS   = 1850;

	logic clk = 1'b0;
	logic arst_n;

	spq_stream_if #(.payload_t(req_t)) req_ch ();
	spq_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	sorted_priority_queue_unit #(
		.DEPTH      (QDEPTH),
		.DATA_WIDTH (32)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the sorted row
	logic signed [31:0] pq_prio [QDEPTH];
	logic signed [31:0] pq_data [QDEPTH];
	int                 pq_count = 0;

	req_t req_pending_q [$];
	rsp_t rsp_due_q [$];
	int   fail_count = 0;
	int   req_taken = 0;
	int   rsp_taken = 0;
	int   n_items = 0;

	task automatic add_req(input logic kind, input logic [31:0] d, input logic [31:0] p);
		req_t r;
		r.req_type      = kind;
		r.item_data     = d;
		r.item_priority = p;
		req_pending_q.push_back(r);
		n_items++;
	endtask

	task automatic pq_apply(input req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		res.status = ST_DONE;
		if (r.req_type == REQ_INSERT) begin
			if (pq_count >= QDEPTH) begin
				res.status = ST_OVER;
			end else begin
				pos = 0;
				// equal priorities stay ahead of the newcomer
				while (pos < pq_count && pq_prio[pos] >= r.item_priority)
					pos++;
				for (int k = pq_count; k > pos; k--) begin
					pq_prio[k] = pq_prio[k-1];
					pq_data[k] = pq_data[k-1];
				end
				pq_prio[pos] = r.item_priority;
				pq_data[pos] = r.item_data;
				pq_count++;
			end
		end else begin
			if (pq_count == 0) begin
				res.status = ST_UNDER;
			end else begin
				res.out_data     = pq_data[0];
				res.out_priority = pq_prio[0];
				for (int k = 1; k < pq_count; k++) begin
					pq_prio[k-1] = pq_prio[k];
					pq_data[k-1] = pq_data[k];
				end
				pq_count--;
			end
		end
		res.occupancy = OCC_W'(pq_count);
		rsp_due_q.push_back(res);
	endtask

	task automatic report_diff(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// monitor: both handshakes sampled at the rising edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				pq_apply(req_ch.payload);
				req_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_taken++;
				if (rsp_due_q.size() == 0) begin
					$display("%0t: result with no request pending, expected none, actual %h",
						$time, rsp_ch.payload);
					fail_count++;
				end else begin
					want = rsp_due_q.pop_front();
					report_diff("status", 32'(want.status), 32'(rsp_ch.payload.status));
					report_diff("out_data", want.out_data, rsp_ch.payload.out_data);
					report_diff("out_priority", want.out_priority,
						rsp_ch.payload.out_priority);
					report_diff("occupancy", 32'(want.occupancy),
						32'(rsp_ch.payload.occupancy));
				end
			end
		end
	end

	// request driver
	int send_gap = 0;
	int send_seen = 0;
	bit send_busy = 1'b0;
	bit send_calm = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_taken != send_seen) begin
				send_seen = req_taken;
				send_busy = 1'b0;
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 10);
			end
			if (!send_busy) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (req_pending_q.size() > 0) begin
					req_ch.payload <= req_pending_q.pop_front();
					req_ch.valid   <= 1'b1;
					send_busy = 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with a long hold-off now and then to back up the input
	int  recv_hold = 0;
	int  recv_seen = 0;
	bit  recv_calm = 1'b0;

	always @(negedge clk) begin
		if (rsp_taken != recv_seen) begin
			recv_seen = rsp_taken;
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			if (rsp_taken % 500 == 250)
				recv_hold = 80;
			else
				recv_hold = recv_calm ? 0 : $urandom_range(0, 10);
		end
		if (recv_hold > 0) begin
			recv_hold--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		int          phase_len;
		int          mix;
		int          prio_kind;
		int          pop_thr;
		logic        kind;
		logic [31:0] prio;

		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready   = 1'b0;

		// directed: empty pop, extremes, ties at both ends, fill past full
		add_req(REQ_POP, 32'hdead_beef, 32'h1234_5678);
		add_req(REQ_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
		add_req(REQ_INSERT, 32'h0000_0000, 32'h8000_0000);
		add_req(REQ_INSERT, 32'h8000_0000, 32'h0000_0000);
		add_req(REQ_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
		add_req(REQ_INSERT, 32'h0000_0001, 32'h8000_0000);
		add_req(REQ_INSERT, 32'h5555_5555, 32'hffff_ffff);
		add_req(REQ_INSERT, 32'haaaa_aaaa, 32'h0000_0001);
		repeat (9)
			add_req(REQ_INSERT, $urandom(), int'($urandom_range(0, 7)) - 4);
		add_req(REQ_INSERT, 32'h0bad_0bad, 32'h7fff_ffff);
		repeat (4)
			add_req(REQ_POP, $urandom(), $urandom());

		while (n_items < N_ITEMS) begin
			phase_len = $urandom_range(10, 60);
			mix       = $urandom_range(0, 2);
			prio_kind = $urandom_range(0, 2);
			case (mix)
				0: pop_thr = 2;   // mostly inserts, runs into overflow
				1: pop_thr = 8;   // mostly pops, runs into underflow
				default: pop_thr = 5;
			endcase
			repeat (phase_len) begin
				kind = ($urandom_range(0, 9) < pop_thr) ? REQ_POP : REQ_INSERT;
				case (prio_kind)
					0: prio = int'($urandom_range(0, 7)) - 4;
					1: prio = $urandom();
					default: begin
						case ($urandom_range(0, 3))
							0: prio = 32'h7fff_ffff;
							1: prio = 32'h8000_0000;
							2: prio = 32'h0000_0000;
							default: prio = 32'hffff_ffff;
						endcase
					end
				endcase
				add_req(kind, $urandom(), prio);
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_pending_q.size() != 0 || send_busy || rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
